FILE: rtl/led_region_colour_average_core_assert.svh
// assertion macros shared by the led region colour average rtl
`ifndef LED_REGION_COLOUR_AVERAGE_CORE_ASSERT_SVH
`define LED_REGION_COLOUR_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication on clk, off while rst_n is low
`define LRCA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define LRCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lrca_pkg.sv
// shared constants and types for the led region colour average core
package lrca_pkg;

  // parameter defaults
  localparam int DEF_MAX_LEDS          = 256;
  localparam int DEF_MAX_REGION_PIXELS = 65536;

  // channel and register widths
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int GAIN_W      = 9;
  localparam int GAMMA_DEPTH = 256;
  localparam int GAMMA_AW    = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 6 * CH_W;
  localparam int OUT_DATA_W  = 4 * CH_W;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd205;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_GAIN = 2'd2;

  // item kinds carried on tuser
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_GAMMA = 1'b1;

  // channel slots in the accumulator and result arrays
  localparam int CH_GREEN = 0;
  localparam int CH_RED   = 1;
  localparam int CH_BLUE  = 2;

  typedef struct packed {
    logic [CH_W-1:0]   black_level;
    logic [CH_W-1:0]   brightness;
    logic [GAIN_W-1:0] smoothing_gain;
  } cfg_t;

endpackage

FILE: rtl/lrca_ram.sv
// generic single write port ram with registered read
module lrca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lrca_fifo.sv
// short job queue between the front and back parts
module lrca_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lrca_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != CNT_FULL;
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  // pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/lrca_front.sv
// front part: takes items, accumulates region sums, queues region ends and table writes
module lrca_front #(
  parameter int MAX_REGION_PIXELS = lrca_pkg::DEF_MAX_REGION_PIXELS,
  localparam int CNT_W = $clog2(MAX_REGION_PIXELS + 1),
  localparam int SUM_W = CNT_W + lrca_pkg::CH_W,
  localparam int JOB_W = 1 + 3 * lrca_pkg::CH_W + 3 * SUM_W + CNT_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lrca_pkg::cfg_t                 cfg,
  input  logic                           clear_busy,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lrca_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tlast,
  input  logic                           in_tuser,
  output logic                           push_valid,
  input  logic                           push_ready,
  output logic [JOB_W-1:0]               push_data
);

  import lrca_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_REGION_PIXELS);

  logic [SUM_W-1:0] sum_r   [NUM_CH];
  logic [SUM_W-1:0] sum_nxt [NUM_CH];
  logic [SUM_W-1:0] sum_upd [NUM_CH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic [CH_W-1:0]  chan    [NUM_CH];
  logic [CH_W-1:0]  led, gidx, gval;
  logic             accept, is_gamma, is_black, take;

  // tdata fields
  assign chan[CH_BLUE]  = in_tdata[CH_W-1:0];
  assign chan[CH_GREEN] = in_tdata[2*CH_W-1:CH_W];
  assign chan[CH_RED]   = in_tdata[3*CH_W-1:2*CH_W];
  assign led            = in_tdata[4*CH_W-1:3*CH_W];
  assign gidx           = in_tdata[5*CH_W-1:4*CH_W];
  assign gval           = in_tdata[6*CH_W-1:5*CH_W];

  assign in_tready = ~clear_busy & push_ready;
  assign accept    = in_tvalid & in_tready;
  assign is_gamma  = in_tuser == ACT_GAMMA;

  // pixel classification: black pixels and overlong regions do not count
  assign is_black = (chan[CH_BLUE] < cfg.black_level) &&
                    (chan[CH_GREEN] < cfg.black_level) &&
                    (chan[CH_RED] < cfg.black_level);
  assign take     = !is_black && (cnt_r < CNT_LIMIT);

  // accumulate
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_upd[c] = sum_r[c] + (take ? SUM_W'(chan[c]) : '0);
    end
    cnt_upd = cnt_r + CNT_W'(take);
  end

  // queue a job on a region end or a table write
  assign push_valid = accept & (is_gamma | in_tlast);
  assign push_data  = {cnt_upd, sum_upd[CH_BLUE], sum_upd[CH_RED], sum_upd[CH_GREEN],
                       gval, gidx, led, in_tuser};

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum_nxt[c] = sum_r[c];
    end
    cnt_nxt = cnt_r;
    if (accept && !is_gamma) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sum_nxt[c] = in_tlast ? '0 : sum_upd[c];
      end
      cnt_nxt = in_tlast ? '0 : cnt_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c] <= '0;
      end
      cnt_r <= '0;
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        sum_r[c] <= sum_nxt[c];
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/lrca_back.sv
// back part: division, gamma lookup, smoothing, colour store and result register
`include "led_region_colour_average_core_assert.svh"

module lrca_back #(
  parameter int MAX_LEDS          = lrca_pkg::DEF_MAX_LEDS,
  parameter int MAX_REGION_PIXELS = lrca_pkg::DEF_MAX_REGION_PIXELS,
  localparam int CNT_W = $clog2(MAX_REGION_PIXELS + 1),
  localparam int SUM_W = CNT_W + lrca_pkg::CH_W,
  localparam int JOB_W = 1 + 3 * lrca_pkg::CH_W + 3 * SUM_W + CNT_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lrca_pkg::cfg_t                  cfg,
  output logic                            clear_busy,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  logic [JOB_W-1:0]                pop_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lrca_pkg::OUT_DATA_W-1:0] out_tdata
);

  import lrca_pkg::*;

  localparam int LED_AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LEDX_W    = LED_AW + CH_W;
  localparam int CLR_DEPTH = (MAX_LEDS > GAMMA_DEPTH) ? MAX_LEDS : GAMMA_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
  localparam int COL_W     = NUM_CH * CH_W;
  localparam int PROD_W    = CH_W + GAIN_W + 2;
  localparam int STEP_W    = PROD_W - CH_W;
  localparam int RES_W     = STEP_W + 1;
  localparam logic [CLR_W-1:0]  CLR_DONE   = CLR_W'(CLR_DEPTH);
  localparam logic [CLR_W-1:0]  CLR_GAMMA  = CLR_W'(GAMMA_DEPTH);
  localparam logic [CLR_W-1:0]  CLR_LEDS   = CLR_W'(MAX_LEDS);
  localparam logic [LEDX_W-1:0] LED_LIMIT  = LEDX_W'(MAX_LEDS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_LOOK = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // job fields
  logic             j_kind;
  logic [CH_W-1:0]  j_led, j_gidx, j_gval;
  logic [SUM_W-1:0] j_sum_g, j_sum_r, j_sum_b;
  logic [CNT_W-1:0] j_count;
  logic [LEDX_W-1:0] j_led_x, led_x;
  logic             j_in_range, pop;

  // datapath registers
  logic [SUM_W-1:0] rem_r   [NUM_CH];
  logic [SUM_W-1:0] rem_nxt [NUM_CH];
  logic [SUM_W-1:0] shifted [NUM_CH];
  logic             qbit    [NUM_CH];
  logic [CH_W-1:0]  quo_r   [NUM_CH];
  logic [CNT_W-1:0] div_r;
  logic [CH_W-1:0]  led_r;
  logic             in_range_r;
  logic [CH_W-1:0]  level_r [NUM_CH];
  logic signed [PROD_W-1:0] prod_r   [NUM_CH];
  logic signed [PROD_W-1:0] prod_nxt [NUM_CH];
  logic signed [CH_W:0]     delta    [NUM_CH];
  logic signed [GAIN_W:0]   gain_s;
  logic signed [RES_W-1:0]  res      [NUM_CH];
  logic [CH_W-1:0]  lvl     [NUM_CH];
  logic [CH_W-1:0]  old     [NUM_CH];
  logic [CH_W-1:0]  new_col [NUM_CH];
  logic [COL_W-1:0] old_col;
  logic [CH_W-1:0]  q_sel, bright_eff, lut_addr;
  logic             out_load;

  // ram ports
  logic                 g_we, g_re;
  logic [GAMMA_AW-1:0]  g_waddr, g_raddr;
  logic [CH_W-1:0]      g_wdata, g_rdata;
  logic                 p_we, p_re;
  logic [LED_AW-1:0]    p_waddr, p_raddr;
  logic [COL_W-1:0]     p_wdata, p_rdata;

  assign {j_count, j_sum_b, j_sum_r, j_sum_g, j_gval, j_gidx, j_led, j_kind} = pop_data;
  assign j_led_x    = {{LED_AW{1'b0}}, j_led};
  assign led_x      = {{LED_AW{1'b0}}, led_r};
  assign j_in_range = j_led_x < LED_LIMIT;

  assign clear_busy = clr_cnt_r != CLR_DONE;
  assign pop_ready  = (state_r == S_IDLE) && !clear_busy;
  assign pop        = pop_valid & pop_ready;
  assign out_load   = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  // restoring division, one quotient bit per channel each step
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      shifted[c] = SUM_W'(div_r) << step_r;
      qbit[c]    = rem_r[c] >= shifted[c];
      rem_nxt[c] = qbit[c] ? rem_r[c] - shifted[c] : rem_r[c];
    end
  end

  // gamma address for the channel being looked up
  always_comb begin
    case (step_r)
      3'd0:    q_sel = quo_r[CH_GREEN];
      3'd1:    q_sel = quo_r[CH_RED];
      default: q_sel = quo_r[CH_BLUE];
    endcase
    bright_eff = (cfg.brightness < cfg.black_level) ? cfg.brightness : cfg.black_level;
    lut_addr   = q_sel - bright_eff;
  end

  // old colour, zero for an led outside the store
  assign old_col       = in_range_r ? p_rdata : '0;
  assign old[CH_GREEN] = old_col[3*CH_W-1:2*CH_W];
  assign old[CH_RED]   = old_col[2*CH_W-1:CH_W];
  assign old[CH_BLUE]  = old_col[CH_W-1:0];

  // smoothing: black averages give zero, step is floor(delta * gain / 256)
  assign gain_s = $signed({1'b0, cfg.smoothing_gain});
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      lvl[c]      = (quo_r[c] < cfg.black_level) ? '0 : level_r[c];
      delta[c]    = $signed({1'b0, lvl[c]}) - $signed({1'b0, old[c]});
      prod_nxt[c] = PROD_W'(delta[c]) * PROD_W'(gain_s);
      res[c]      = RES_W'($signed({1'b0, old[c]})) +
                    RES_W'($signed(prod_r[c][PROD_W-1:CH_W]));
      if (res[c][RES_W-1]) begin
        new_col[c] = '0;
      end else if (res[c][RES_W-2:CH_W] != '0) begin
        new_col[c] = '1;
      end else begin
        new_col[c] = res[c][CH_W-1:0];
      end
    end
  end

  // gamma table port: clearing pass, table writes, lookups
  always_comb begin
    if (clear_busy) begin
      g_we    = clr_cnt_r < CLR_GAMMA;
      g_waddr = clr_cnt_r[GAMMA_AW-1:0];
      g_wdata = '0;
    end else begin
      g_we    = pop && (j_kind == ACT_GAMMA);
      g_waddr = j_gidx;
      g_wdata = j_gval;
    end
    g_re    = (state_r == S_LOOK) && (step_r != 3'd3);
    g_raddr = lut_addr;
  end

  // colour store port: clearing pass, read on job start, write on result
  always_comb begin
    if (clear_busy) begin
      p_we    = clr_cnt_r < CLR_LEDS;
      p_waddr = clr_cnt_r[LED_AW-1:0];
      p_wdata = '0;
    end else begin
      p_we    = out_load && in_range_r;
      p_waddr = led_x[LED_AW-1:0];
      p_wdata = {new_col[CH_GREEN], new_col[CH_RED], new_col[CH_BLUE]};
    end
    p_re    = pop && (j_kind == ACT_PIXEL);
    p_raddr = j_led_x[LED_AW-1:0];
  end

  lrca_ram #(
    .WIDTH (CH_W),
    .DEPTH (GAMMA_DEPTH)
  ) u_gamma_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  lrca_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_LEDS)
  ) u_colour_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    clr_cnt_nxt    = clear_busy ? clr_cnt_r + CLR_W'(1) : clr_cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (pop && (j_kind == ACT_PIXEL)) begin
          state_nxt = S_DIV;
          step_nxt  = 3'd7;
        end
      end
      S_DIV: begin
        if (step_r == 3'd0) begin
          state_nxt = S_LOOK;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      S_LOOK: begin
        if (step_r == 3'd3) begin
          state_nxt = S_MUL;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_MUL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt      = S_IDLE;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (pop && (j_kind == ACT_PIXEL)) begin
          rem_r[CH_GREEN] <= j_sum_g;
          rem_r[CH_RED]   <= j_sum_r;
          rem_r[CH_BLUE]  <= j_sum_b;
          for (int c = 0; c < NUM_CH; c++) begin
            quo_r[c] <= '0;
          end
          div_r      <= (j_count == '0) ? CNT_W'(1) : j_count;
          led_r      <= j_led;
          in_range_r <= j_in_range;
        end
      end
      S_DIV: begin
        for (int c = 0; c < NUM_CH; c++) begin
          rem_r[c] <= rem_nxt[c];
          quo_r[c] <= {quo_r[c][CH_W-2:0], qbit[c]};
        end
      end
      S_LOOK: begin
        case (step_r)
          3'd1:    level_r[CH_GREEN] <= g_rdata;
          3'd2:    level_r[CH_RED]   <= g_rdata;
          3'd3:    level_r[CH_BLUE]  <= g_rdata;
          default: ;
        endcase
      end
      S_MUL: begin
        for (int c = 0; c < NUM_CH; c++) begin
          prod_r[c] <= prod_nxt[c];
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_tdata_r <= {new_col[CH_BLUE], new_col[CH_RED], new_col[CH_GREEN], led_r};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `LRCA_ASSERT_SAME(a_lut_stable, state_r == S_LOOK, !g_we, "gamma table written during lookup")
  `LRCA_ASSERT_NEXT(a_div_len, (state_r == S_DIV) && (step_r == 3'd0), state_r == S_LOOK, "division overran")
  `LRCA_ASSERT_SAME(a_clear_quiet, clear_busy, (state_r == S_IDLE) && !out_tvalid_r && !pop_ready, "activity during clearing pass")
  `LRCA_ASSERT_SAME(a_out_src, $rose(out_tvalid_r), $past(state_r == S_OUT), "result without smoothing step")

endmodule

FILE: rtl/led_region_colour_average_core.sv
// top level of the led region colour average core
//
//  channel  dir  handshake         payload
//  in_      in   tvalid / tready   tdata pixel,led,gamma idx/val; tlast region end; tuser kind
//  out_     out  tvalid / tready   tdata led, green, red, blue
//  cfg_     in   valid / ready     index, data (black level, brightness, smoothing gain)
//
// pixel items are taken one per clock while input is not stalled; the back part writes
// a gamma job into the table as it takes it; a region end goes through start, 8 divide
// steps, gamma ram lookups one channel at a time on its single read port, multiply and
// result; a 4-entry queue buffers jobs. after reset a clearing pass zeroes the gamma table
// and colour store; no input item is taken meanwhile, configuration writes are still taken
// otherwise input stalls only when the job queue is full; the result register frees the back part
module led_region_colour_average_core #(
  parameter int MAX_LEDS          = lrca_pkg::DEF_MAX_LEDS,
  parameter int MAX_REGION_PIXELS = lrca_pkg::DEF_MAX_REGION_PIXELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [23:0] pixel_word, [31:24] led_index, [39:32] gamma_index, [47:40] gamma_value
  input  logic [lrca_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,   // last_in_region
  input  logic                            in_tuser,   // action
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] led_number, [15:8] green_out, [23:16] red_out, [31:24] blue_out
  output logic [lrca_pkg::OUT_DATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lrca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrca_pkg::GAIN_W-1:0]     cfg_data
);

  import lrca_pkg::*;

  localparam int CNT_W = $clog2(MAX_REGION_PIXELS + 1);
  localparam int SUM_W = CNT_W + CH_W;
  localparam int JOB_W = 1 + 3 * CH_W + 3 * SUM_W + CNT_W;

  cfg_t             cfg_r;
  logic             clear_busy;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  logic [JOB_W-1:0] push_data, pop_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.black_level    <= '0;
      cfg_r.brightness     <= '0;
      cfg_r.smoothing_gain <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLACK_LEVEL: cfg_r.black_level    <= cfg_data[CH_W-1:0];
        CFG_BRIGHTNESS:  cfg_r.brightness     <= cfg_data[CH_W-1:0];
        CFG_SMOOTH_GAIN: cfg_r.smoothing_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  lrca_front #(
    .MAX_REGION_PIXELS (MAX_REGION_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .clear_busy (clear_busy),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lrca_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lrca_back #(
    .MAX_LEDS          (MAX_LEDS),
    .MAX_REGION_PIXELS (MAX_REGION_PIXELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .clear_busy (clear_busy),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
